>>> src/cke_pkg.sv
// ----------------------------------------------------------------------------
// cke_pkg: shared types, codes and character priority table
// Command and register codes, queue entry layout and the collation table
// used by the collation key encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cke_pkg;

    localparam int CMD_W   = 3;
    localparam int VALUE_W = 64;
    localparam int BYTE_W  = 8;
    localparam int ADDR_W  = 3;
    localparam int QDEPTH  = 4;
    localparam int QAW     = $clog2(QDEPTH);
    localparam int NUM_BYTES = VALUE_W / BYTE_W;
    localparam int REM_W   = $clog2(NUM_BYTES + 1);

    localparam logic [CMD_W-1:0] CMD_BOOL   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_NUMBER = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GEO    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CHAR   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_END    = 3'd5;

    localparam logic [ADDR_W-1:0] REG_FALSE = 3'd0;
    localparam logic [ADDR_W-1:0] REG_TRUE  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_NEG   = 3'd2;
    localparam logic [ADDR_W-1:0] REG_POS   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_TEXT  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_GEO   = 3'd5;

    localparam logic [VALUE_W-1:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VALUE_W-1:0] INF_BITS = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic               is_num;
        logic [BYTE_W-1:0]  head;
        logic [VALUE_W-1:0] bits;
    } cke_entry_t;

    function automatic logic [BYTE_W-1:0] char_priority(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] p;
        logic [BYTE_W-1:0] c2;
        c2 = {c[BYTE_W-2:0], 1'b0};
        p = c;
        if (!c[BYTE_W-1])
        begin
            case (c)
                8'd9:   p = 8'd1;
                8'd10:  p = 8'd2;
                8'd13:  p = 8'd3;
                8'd32:  p = 8'd4;
                8'd127: p = 8'd4;
                8'd96:  p = 8'd5;
                8'd94:  p = 8'd6;
                8'd95:  p = 8'd7;
                8'd45:  p = 8'd8;
                8'd44:  p = 8'd9;
                8'd59:  p = 8'd10;
                8'd58:  p = 8'd11;
                8'd33:  p = 8'd12;
                8'd63:  p = 8'd13;
                8'd46:  p = 8'd14;
                8'd39:  p = 8'd15;
                8'd34:  p = 8'd16;
                8'd40:  p = 8'd17;
                8'd41:  p = 8'd18;
                8'd91:  p = 8'd19;
                8'd93:  p = 8'd20;
                8'd123: p = 8'd21;
                8'd125: p = 8'd22;
                8'd64:  p = 8'd23;
                8'd42:  p = 8'd24;
                8'd47:  p = 8'd25;
                8'd92:  p = 8'd26;
                8'd38:  p = 8'd27;
                8'd35:  p = 8'd28;
                8'd37:  p = 8'd29;
                8'd43:  p = 8'd30;
                8'd60:  p = 8'd31;
                8'd61:  p = 8'd32;
                8'd62:  p = 8'd33;
                8'd124: p = 8'd34;
                8'd126: p = 8'd35;
                8'd36:  p = 8'd36;
                default:
                begin
                    if (c >= 8'd48 && c <= 8'd57)
                        p = c - 8'd11;
                    else if (c >= 8'd97 && c <= 8'd122)
                        p = c2 - 8'd147;
                    else if (c >= 8'd65 && c <= 8'd90)
                        p = c2 - 8'd82;
                    else if (c <= 8'd8)
                        p = c + 8'd99;
                    else if (c == 8'd11 || c == 8'd12)
                        p = c + 8'd97;
                    else
                        p = c + 8'd96;
                end
            endcase
        end
        return p;
    endfunction

endpackage

`default_nettype wire

>>> src/cke_front.sv
// ----------------------------------------------------------------------------
// cke_front: input stage and classifier
// Holds the tag registers, accepts items and turns each known one into a queue
// entry: a head byte and, for numbers, the eight payload bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module cke_front
    import cke_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [ADDR_W-1:0]  cfg_addr,
    input  wire logic [BYTE_W-1:0]  cfg_data,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,
    input  wire logic [CMD_W-1:0]   s_tuser,
    output logic                    push,
    output cke_entry_t              push_entry,
    input  wire logic               q_full
);

    logic [BYTE_W-1:0] false_tag_reg;
    logic [BYTE_W-1:0] true_tag_reg;
    logic [BYTE_W-1:0] neg_tag_reg;
    logic [BYTE_W-1:0] pos_tag_reg;
    logic [BYTE_W-1:0] text_tag_reg;
    logic [BYTE_W-1:0] geo_tag_reg;

    logic       f_valid_reg, f_valid_next;
    cke_entry_t f_entry_reg, f_entry_next;

    logic               known;
    logic               neg;
    logic [VALUE_W-1:0] mag;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            false_tag_reg <= 8'd2;
            true_tag_reg  <= 8'd3;
            neg_tag_reg   <= 8'd4;
            pos_tag_reg   <= 8'd5;
            text_tag_reg  <= 8'd6;
            geo_tag_reg   <= 8'd9;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_FALSE: false_tag_reg <= cfg_data;
                REG_TRUE:  true_tag_reg  <= cfg_data;
                REG_NEG:   neg_tag_reg   <= cfg_data;
                REG_POS:   pos_tag_reg   <= cfg_data;
                REG_TEXT:  text_tag_reg  <= cfg_data;
                REG_GEO:   geo_tag_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign s_tready   = !f_valid_reg || !q_full;
    assign push       = f_valid_reg && !q_full;
    assign push_entry = f_entry_reg;

    assign mag = s_tdata & MAG_MASK;
    assign neg = s_tdata[VALUE_W-1] && (mag <= INF_BITS) && (mag != '0);

    always_comb
    begin
        known        = 1'b1;
        f_entry_next = f_entry_reg;
        f_entry_next.is_num = 1'b0;
        f_entry_next.bits   = s_tdata;
        case (s_tuser)
            CMD_BOOL:   f_entry_next.head = s_tdata[0] ? true_tag_reg : false_tag_reg;
            CMD_NUMBER:
            begin
                f_entry_next.is_num = 1'b1;
                f_entry_next.head   = neg ? neg_tag_reg : pos_tag_reg;
                f_entry_next.bits   = neg ? ~s_tdata : s_tdata;
            end
            CMD_TEXT:   f_entry_next.head = text_tag_reg;
            CMD_GEO:    f_entry_next.head = geo_tag_reg;
            CMD_CHAR:   f_entry_next.head = char_priority(s_tdata[BYTE_W-1:0]);
            CMD_END:    f_entry_next.head = '0;
            default:    known = 1'b0;
        endcase
        f_valid_next = f_valid_reg;
        if (s_tready)
            f_valid_next = s_tvalid && known;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else
            f_valid_reg <= f_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            f_entry_reg <= f_entry_next;
    end

endmodule

`default_nettype wire

>>> src/cke_queue.sv
// ----------------------------------------------------------------------------
// cke_queue: entry queue
// Small first-in first-out buffer of classified entries between the
// input stage and the byte serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module cke_queue
    import cke_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire cke_entry_t push_entry,
    output logic            full,
    input  wire logic       pop,
    output cke_entry_t      pop_entry,
    output logic            empty
);

    cke_entry_t mem [QDEPTH];

    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    assign full      = (count_reg == QDEPTH[QAW:0]);
    assign empty     = (count_reg == '0);
    assign pop_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

>>> src/cke_back.sv
// ----------------------------------------------------------------------------
// cke_back: byte serializer
// Pops queue entries and sends the head byte, then for numbers the eight
// payload bytes most significant first, through a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module cke_back
    import cke_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cke_entry_t        pop_entry,
    input  wire logic              q_empty,
    output logic                   pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [BYTE_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;
    logic [VALUE_W-1:0]  shift_reg, shift_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic                adv;

    assign adv      = !m_valid_reg || m_tready;
    assign pop      = adv && (rem_reg == '0) && !q_empty;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        shift_next   = shift_reg;
        rem_next     = rem_reg;
        if (adv)
        begin
            if (rem_reg != '0)
            begin
                m_valid_next = 1'b1;
                m_data_next  = shift_reg[VALUE_W-1 -: BYTE_W];
                m_last_next  = (rem_reg == REM_W'(1));
                shift_next   = {shift_reg[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                rem_next     = rem_reg - 1'b1;
            end
            else if (!q_empty)
            begin
                m_valid_next = 1'b1;
                m_data_next  = pop_entry.head;
                m_last_next  = !pop_entry.is_num;
                shift_next   = pop_entry.bits;
                rem_next     = pop_entry.is_num ? REM_W'(NUM_BYTES) : '0;
            end
            else
            begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            rem_reg     <= '0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            rem_reg     <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        shift_reg  <= shift_next;
    end

endmodule

`default_nettype wire

>>> src/collation_key_encoder.sv
// ----------------------------------------------------------------------------
// collation_key_encoder: order-preserving key byte encoder
// an accepted item passes the input register and the queue to the output register
// throughput: one key byte per cycle while the output is not stalled; bool, tag,
// character and end items give one key byte each, a number gives nine key bytes
// a 4-entry queue lets input keep flowing while output stalls
// reset: asynchronous active-low, tags return to defaults, queue empties
// ----------------------------------------------------------------------------
`default_nettype none

module collation_key_encoder
    import cke_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [ADDR_W-1:0]  cfg_addr,
    input  wire logic [BYTE_W-1:0]  cfg_data,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [VALUE_W-1:0] s_tdata,   // value
    input  wire logic [CMD_W-1:0]   s_tuser,   // cmd
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [BYTE_W-1:0]       m_tdata,   // out_byte
    output logic                    m_tlast
);

    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    cke_entry_t push_entry;
    cke_entry_t pop_entry;

    cke_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    cke_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    cke_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_entry  (pop_entry),
        .q_empty    (q_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: collation key encoder
// Drives typed values (booleans, raw double bits, plain and geohash strings,
// stray characters and unknown commands) over the input stream and checks
// every key byte against an in-bench collation predictor. Tag registers are
// changed between phases while the encoder is idle, and both stream sides
// pause at random.
// ----------------------------------------------------------------------------

module testbench;

    import cke_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] key_byte;
        logic              final_byte;
    } key_byte_t;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [BYTE_W-1:0]  typed_byte;
    } stim_row_t;

    localparam logic [CMD_W-1:0]   CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0]   CMD_SPARE_HI = 3'd7;
    localparam logic [ADDR_W-1:0]  REG_SPARE_HI = 3'd7;
    localparam int                 NUM_TAGS     = 6;
    localparam int                 NUM_PHASES   = 5;
    localparam int                 PHASE_ITEMS  = 82;
    localparam int                 DRAIN_LIMIT  = 20000;
    localparam logic [VALUE_W-1:0] SIGN_BIT     = 64'h8000_0000_0000_0000;
    localparam logic [VALUE_W-1:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam int TAGS_ZERO = 0;
    localparam int TAGS_ONES = 1;
    localparam int TAGS_RAND = 2;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               cfg_we   = 1'b0;
    logic [ADDR_W-1:0]  cfg_addr = '0;
    logic [BYTE_W-1:0]  cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;   // value
    logic [CMD_W-1:0]   s_tuser  = '0;   // cmd
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [BYTE_W-1:0]  m_tdata;         // out_byte
    logic               m_tlast;

    key_byte_t         key_bytes_due [$];
    key_byte_t         oldest_due;
    logic [BYTE_W-1:0] tag_reg [NUM_TAGS];
    logic [BYTE_W-1:0] collate_rank [256];

    int fail_count  = 0;
    int src_calm    = 0;
    int sink_calm   = 0;
    int sink_hold   = 0;
    int phase_items = 0;
    bit pauses_on   = 1'b1;

    stim_row_t directed_rows [0:25] = '{
        '{CMD_BOOL,     64'd0,                  1'b1, 8'd2},
        '{CMD_BOOL,     64'd1,                  1'b1, 8'd3},
        '{CMD_BOOL,     64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 8'd2},
        '{CMD_TEXT,     64'd0,                  1'b1, 8'd6},
        '{CMD_CHAR,     64'd9,                  1'b1, 8'd1},
        '{CMD_CHAR,     64'd127,                1'b1, 8'd4},
        '{CMD_CHAR,     64'd0,                  1'b1, 8'd99},
        '{CMD_CHAR,     64'hFFFF_FFFF_FFFF_FF5A, 1'b1, 8'd98},
        '{CMD_CHAR,     64'h80,                 1'b1, 8'h80},
        '{CMD_CHAR,     64'hFF,                 1'b1, 8'hFF},
        '{CMD_END,      64'd0,                  1'b1, 8'd0},
        '{CMD_GEO,      ALL_ONES,               1'b1, 8'd9},
        '{CMD_CHAR,     64'h30,                 1'b1, 8'd37},
        '{CMD_END,      ALL_ONES,               1'b1, 8'd0},
        '{CMD_CHAR,     64'h61,                 1'b0, 8'd0},
        '{CMD_NUMBER,   64'd0,                  1'b0, 8'd0},
        '{CMD_NUMBER,   SIGN_BIT,               1'b0, 8'd0},
        '{CMD_NUMBER,   64'h3FF0_0000_0000_0000, 1'b0, 8'd0},
        '{CMD_NUMBER,   64'hBFF0_0000_0000_0000, 1'b0, 8'd0},
        '{CMD_NUMBER,   INF_BITS,               1'b0, 8'd0},
        '{CMD_NUMBER,   SIGN_BIT | INF_BITS,    1'b0, 8'd0},
        '{CMD_NUMBER,   64'h7FF0_0000_0000_0001, 1'b0, 8'd0},
        '{CMD_NUMBER,   ALL_ONES,               1'b0, 8'd0},
        '{CMD_NUMBER,   64'h8000_0000_0000_0001, 1'b0, 8'd0},
        '{CMD_SPARE_LO, 64'd0,                  1'b0, 8'd0},
        '{CMD_SPARE_HI, ALL_ONES,               1'b0, 8'd0}
    };

    collation_key_encoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void build_collation_ranks();
        string punct;
        int    rank;
        int    extra;
        punct = " `^_-,;:!?.'\"()[]{}@*/\\&#%+<=>|~$";
        for (int c = 0; c < 256; c++)
            collate_rank[c] = '0;
        collate_rank[9]  = 8'd1;
        collate_rank[10] = 8'd2;
        collate_rank[13] = 8'd3;
        rank = 4;
        for (int i = 0; i < punct.len(); i++)
        begin
            collate_rank[int'(punct[i])] = rank[BYTE_W-1:0];
            rank++;
        end
        for (int i = 0; i < 10; i++)
        begin
            collate_rank[8'h30 + i] = rank[BYTE_W-1:0];
            rank++;
        end
        for (int i = 0; i < 26; i++)
        begin
            collate_rank[8'h61 + i] = rank[BYTE_W-1:0];
            collate_rank[8'h41 + i] = rank[BYTE_W-1:0] + 8'd1;
            rank += 2;
        end
        // unlisted low codes follow in code order
        extra = 99;
        for (int c = 0; c < 127; c++)
        begin
            if (collate_rank[c] == '0)
            begin
                collate_rank[c] = extra[BYTE_W-1:0];
                extra++;
            end
        end
        collate_rank[127] = collate_rank[32];
        for (int c = 128; c < 256; c++)
            collate_rank[c] = c[BYTE_W-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_pause(inout int calm);
        int r;
        if (!pauses_on)
            return 0;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
            calm = $urandom_range(10, 50);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic queue_key_byte(input logic [BYTE_W-1:0] b, input logic l);
        key_bytes_due.insert(key_bytes_due.size(), key_byte_t'{b, l});
    endtask

    task automatic predict_key(input logic [CMD_W-1:0] c, input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [VALUE_W-1:0] bits;
        logic               neg;
        mag = v & MAG_MASK;
        case (c)
            CMD_BOOL:
                queue_key_byte(v[0] ? tag_reg[REG_TRUE] : tag_reg[REG_FALSE], 1'b1);
            CMD_NUMBER:
            begin
                // minus zero and nan sort with the non-negatives
                neg  = v[VALUE_W-1] && mag != '0 && mag <= INF_BITS;
                bits = neg ? ~v : v;
                queue_key_byte(neg ? tag_reg[REG_NEG] : tag_reg[REG_POS], 1'b0);
                for (int k = 0; k < NUM_BYTES; k++)
                    queue_key_byte(bits[VALUE_W-1-8*k -: 8], k == NUM_BYTES - 1);
            end
            CMD_TEXT:
                queue_key_byte(tag_reg[REG_TEXT], 1'b1);
            CMD_GEO:
                queue_key_byte(tag_reg[REG_GEO], 1'b1);
            CMD_CHAR:
                queue_key_byte(collate_rank[v[BYTE_W-1:0]], 1'b1);
            CMD_END:
                queue_key_byte(8'd0, 1'b1);
            default:
                ;
        endcase
    endtask

    task automatic send_item(input logic [CMD_W-1:0]   c,
                             input logic [VALUE_W-1:0] v,
                             input logic               typed = 1'b0,
                             input logic [BYTE_W-1:0]  typed_byte = '0);
        int gap;
        gap = pick_pause(src_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (typed)
            queue_key_byte(typed_byte, 1'b1);
        else
            predict_key(c, v);
        if (c <= CMD_END)
            phase_items++;
    endtask

    task automatic drain_keys();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (key_bytes_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        // let ignored items clear the pipeline
        repeat (8) @(posedge clk);
    endtask

    task automatic load_tags(input int mode);
        logic [BYTE_W-1:0] d;
        for (int i = REG_FALSE; i <= REG_SPARE_HI; i++)
        begin
            case (mode)
                TAGS_ZERO: d = '0;
                TAGS_ONES: d = '1;
                default:   d = 8'($urandom_range(0, 255));
            endcase
            cfg_we   <= 1'b1;
            cfg_addr <= i[ADDR_W-1:0];
            cfg_data <= d;
            if (i <= REG_GEO)
                tag_reg[i] = d;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [VALUE_W-1:0] number_value();
        logic [VALUE_W-1:0] v;
        v = rand64();
        case ($urandom_range(0, 11))
            0:       v = '0;
            1:       v = SIGN_BIT;
            2:       v = INF_BITS;
            3:       v = SIGN_BIT | INF_BITS;
            4:       v = INF_BITS + 64'd1;
            5:       v = (v | INF_BITS) & MAG_MASK;
            6:       v = v | INF_BITS | SIGN_BIT;
            7:       v = SIGN_BIT | 64'd1;
            8:       v = v | SIGN_BIT;
            9:       v = v & MAG_MASK;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [VALUE_W-1:0] char_value();
        logic [VALUE_W-1:0] v;
        v = ($urandom_range(0, 3) == 0) ? rand64() : '0;
        case ($urandom_range(0, 9))
            7:       v[BYTE_W-1:0] = ($urandom_range(0, 1) != 0)
                                     ? 8'($urandom_range(0, 31)) : 8'd127;
            8:       v[BYTE_W-1:0] = 8'($urandom_range(128, 255));
            9:       v[BYTE_W-1:0] = 8'($urandom_range(0, 255));
            default: v[BYTE_W-1:0] = 8'($urandom_range(32, 126));
        endcase
        return v;
    endfunction

    task automatic send_random_group();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 15)
            send_item(CMD_BOOL, rand64());
        else if (r < 45)
            send_item(CMD_NUMBER, number_value());
        else if (r < 85)
        begin
            n = $urandom_range(0, 8);
            send_item($urandom_range(0, 1) ? CMD_TEXT : CMD_GEO,
                      $urandom_range(0, 1) ? rand64() : '0);
            repeat (n)
                send_item(CMD_CHAR, char_value());
            send_item(CMD_END, $urandom_range(0, 1) ? rand64() : '0);
        end
        else if (r < 95)
            send_item($urandom_range(0, 1) ? CMD_CHAR : CMD_END, char_value());
        else
            send_item($urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI, rand64());
    endtask

    always @(posedge clk)
    begin
        if (sink_hold > 0)
        begin
            sink_hold = sink_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            sink_hold = pick_pause(sink_calm);
            m_tready <= (sink_hold == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (key_bytes_due.size() == 0)
            begin
                $error("unexpected item: out_byte %0h last %0b", m_tdata, m_tlast);
                fail_count++;
            end
            else
            begin
                oldest_due = key_bytes_due.pop_front();
                if (m_tdata !== oldest_due.key_byte)
                begin
                    $error("out_byte: expected %0h, got %0h", oldest_due.key_byte, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== oldest_due.final_byte)
                begin
                    $error("last: expected %0b, got %0b", oldest_due.final_byte, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        build_collation_ranks();
        tag_reg[REG_FALSE] = 8'd2;
        tag_reg[REG_TRUE]  = 8'd3;
        tag_reg[REG_NEG]   = 8'd4;
        tag_reg[REG_POS]   = 8'd5;
        tag_reg[REG_TEXT]  = 8'd6;
        tag_reg[REG_GEO]   = 8'd9;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].cmd, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].typed_byte);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_keys();
            load_tags(phase == 0 ? TAGS_ZERO : phase == 1 ? TAGS_ONES : TAGS_RAND);
            // one phase runs back to back on both sides
            pauses_on   = (phase != 3);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_random_group();
        end

        pauses_on = 1'b1;
        drain_keys();
        if (key_bytes_due.size() != 0)
        begin
            $error("%0d expected key bytes never arrived", key_bytes_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> collation_key_encoder.f
src/cke_pkg.sv
src/cke_front.sv
src/cke_queue.sv
src/cke_back.sv
src/collation_key_encoder.sv
tb/testbench.sv
